// ===== src/cdq_pkg.sv =====
// Package for the circular deque: sizes, operation and status codes, word types.
// Used by circular_deque_unit; depends on nothing.
package cdq_pkg;

	localparam int DEPTH      = 64;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CAP_W      = 7;
	localparam int WORD_W     = 32;
	localparam int CAP_RESET  = 64;
	// capacity reset value, clipped to the ring, minus one
	localparam int CAPM1_RESET = ((CAP_RESET > DEPTH) ? DEPTH : CAP_RESET) - 1;

	// operation codes
	localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
	localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [1:0] OP_POP_BACK   = 2'd2;
	localparam logic [1:0] OP_POP_FRONT  = 2'd3;

	// status codes
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [WORD_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] popped_value;
		logic                     is_empty;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
	} rsp_t;

endpackage

// ===== src/cdq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/circular_deque_unit.sv =====
// Top level of the circular deque: index control, cached end words and the ring RAM.
// Depends on cdq_pkg and cdq_ram.
//
//  channel   handshake                 payload          direction
//  command   start / busy              req (req_t)      in
//  result    done (one-cycle strobe)   result (rsp_t)   out
//  config    cfg_valid / cfg_ready     cfg_data [6:0]   in
//
// Each word is accepted, then its result is strobed from the response state. That state
// covers the registered read of the ring RAM, which supplies the new end word after a pop.
// Reset empties the queue and sets capacity to 64; the RAM itself is not cleared.
// A capacity write also empties the queue; cfg_ready is low while busy or while start is high.
// The receiver cannot stall; done lasts one cycle.
module circular_deque_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  cdq_pkg::req_t               req,
	output logic                        done,
	output cdq_pkg::rsp_t               result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cdq_pkg::CAP_W-1:0]   cfg_data
);
	import cdq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RESP = 1'b1;

	logic              state_q;
	logic [IDX_W-1:0]  head_q, tail_q, capm1_q;
	logic              empty_q;
	logic [WORD_W-1:0] front_q, back_q;

	logic [1:0]        status_s1;
	logic [WORD_W-1:0] popped_s1;
	logic              fix_front_s1, fix_back_s1;

	logic              accept, cfg_wr;
	logic [IDX_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;
	logic              full;

	// next-state values of the accept cycle
	logic [IDX_W-1:0]  head_d, tail_d;
	logic              empty_d;
	logic [WORD_W-1:0] front_d, back_d;
	logic [1:0]        status_d;
	logic [WORD_W-1:0] popped_d;
	logic              fix_front_d, fix_back_d;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic              re;
	logic [IDX_W-1:0]  raddr;
	logic [WORD_W-1:0] rdata;
	logic [IDX_W-1:0]  capm1_d;

	assign busy      = (state_q == ST_RESP);
	assign done      = busy;
	// hold off a capacity write while a command is in flight or being offered
	assign cfg_ready = ~busy & ~start;
	assign accept    = start & ~busy;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// ring stepping within the capacity in use
	assign head_inc = (head_q == capm1_q) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? capm1_q : head_q - 1'b1;
	assign tail_inc = (tail_q == capm1_q) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? capm1_q : tail_q - 1'b1;
	assign full     = ~empty_q & (tail_inc == head_q);

	// clip the written capacity to 1..DEPTH, keep it minus one
	always_comb begin
		if (cfg_data == '0) begin
			capm1_d = '0;
		end else if (int'(cfg_data) > DEPTH) begin
			capm1_d = IDX_W'(DEPTH - 1);
		end else begin
			capm1_d = IDX_W'(cfg_data - 1'b1);
		end
	end

	// decide the operation
	always_comb begin
		head_d      = head_q;
		tail_d      = tail_q;
		empty_d     = empty_q;
		front_d     = front_q;
		back_d      = back_q;
		status_d    = STAT_DONE;
		popped_d    = '0;
		fix_front_d = 1'b0;
		fix_back_d  = 1'b0;
		we          = 1'b0;
		waddr       = '0;
		re          = 1'b0;
		raddr       = '0;
		if (req.kind == OP_PUSH_BACK || req.kind == OP_PUSH_FRONT) begin
			if (empty_q) begin
				head_d  = '0;
				tail_d  = '0;
				empty_d = 1'b0;
				front_d = req.push_value;
				back_d  = req.push_value;
				we      = accept;
				waddr   = '0;
			end else if (full) begin
				status_d = STAT_FULL;
			end else if (req.kind == OP_PUSH_BACK) begin
				tail_d = tail_inc;
				back_d = req.push_value;
				we     = accept;
				waddr  = tail_inc;
			end else begin
				head_d  = head_dec;
				front_d = req.push_value;
				we      = accept;
				waddr   = head_dec;
			end
		end else begin
			if (empty_q) begin
				status_d = STAT_EMPTY;
			end else begin
				popped_d = (req.kind == OP_POP_BACK) ? back_q : front_q;
				if (head_q == tail_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b1;
				end else if (req.kind == OP_POP_BACK) begin
					tail_d     = tail_dec;
					fix_back_d = 1'b1;
					re         = accept;
					raddr      = tail_dec;
				end else begin
					head_d      = head_inc;
					fix_front_d = 1'b1;
					re          = accept;
					raddr       = head_inc;
				end
			end
		end
	end

	cdq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(req.push_value),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// sequencer, indices and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			capm1_q <= IDX_W'(CAPM1_RESET);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// a capacity write empties the queue
			if (cfg_wr) begin
				capm1_q <= capm1_d;
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b1;
			end else if (accept) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				empty_q <= empty_d;
			end
		end
	end

	// hold the cached end words and the pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			front_q      <= front_d;
			back_q       <= back_d;
			status_s1    <= status_d;
			popped_s1    <= popped_d;
			fix_front_s1 <= fix_front_d;
			fix_back_s1  <= fix_back_d;
		end else if (busy) begin
			if (fix_front_s1) begin
				front_q <= rdata;
			end
			if (fix_back_s1) begin
				back_q <= rdata;
			end
		end
	end

	// drive the result word
	always_comb begin
		result.status       = status_s1;
		result.popped_value = popped_s1;
		result.is_empty     = empty_q;
		result.front_value  = empty_q ? '0 : (fix_front_s1 ? rdata : front_q);
		result.back_value   = empty_q ? '0 : (fix_back_s1 ? rdata : back_q);
	end

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted word gave no result");

	a_empty_ends_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.is_empty |-> result.front_value == '0 && result.back_value == '0)
		else $error("empty queue shows end words");

	a_refused_pops_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != STAT_DONE |-> result.popped_value == '0)
		else $error("refused operation popped a word");

	a_index_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> head_q <= capm1_q && tail_q <= capm1_q)
		else $error("index beyond capacity");

	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> empty_q)
		else $error("capacity write left queue occupied");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for circular_deque_unit: pushes and pops across capacity settings.
// Depends on cdq_pkg for the word structs, op and status codes; carries its own deque predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	req_t             req       = '0;
	logic             done;
	rsp_t             result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data  = '0;

	// predicted deque state
	logic [WORD_W-1:0] ring_copy [DEPTH];
	logic [IDX_W-1:0]  head_at     = '0;
	logic [IDX_W-1:0]  tail_at     = '0;
	logic              deque_empty = 1'b1;
	logic [CAP_W-1:0]  cap_setting = 7'(CAP_RESET);

	req_t cmd_backlog [$];
	rsp_t rsp_due [$];

	bit gaps_on  = 1'b1;
	int gap_left = 0;

	int items_sent     = 0;
	int results_seen   = 0;
	int faults         = 0;
	int full_drops     = 0;
	int empty_refusals = 0;
	int cfg_writes     = 0;

	// capacities for the random phases: extremes, out-of-range codes and odd sizes
	logic [CAP_W-1:0] cap_plan [12] = '{7'd1, 7'd2, 7'd3, 7'd0, 7'd127, 7'd5,
		7'd65, 7'd17, 7'd100, 7'd8, 7'd64, 7'd64};

	circular_deque_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// clip the capacity code to the ring: zero acts as one, above DEPTH acts as DEPTH
	function automatic int ring_span(logic [CAP_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > DEPTH)
			return DEPTH;
		return int'(c);
	endfunction

	// advance the predicted deque by one command word and return its result
	function automatic rsp_t deque_step(req_t r);
		rsp_t o;
		int   span;
		int   hd;
		int   tl;
		span     = ring_span(cap_setting);
		hd       = int'(head_at);
		tl       = int'(tail_at);
		o        = '0;
		o.status = STAT_DONE;
		if (r.kind == OP_PUSH_BACK || r.kind == OP_PUSH_FRONT) begin
			if (deque_empty) begin
				// first word lands in slot 0 whichever end it is pushed at
				hd           = 0;
				tl           = 0;
				deque_empty  = 1'b0;
				ring_copy[0] = r.push_value;
			end else if ((tl + 1) % span == hd) begin
				o.status = STAT_FULL;
				full_drops++;
			end else if (r.kind == OP_PUSH_BACK) begin
				tl            = (tl + 1) % span;
				ring_copy[tl] = r.push_value;
			end else begin
				hd            = (hd == 0) ? span - 1 : hd - 1;
				ring_copy[hd] = r.push_value;
			end
		end else if (deque_empty) begin
			o.status = STAT_EMPTY;
			empty_refusals++;
		end else begin
			o.popped_value = (r.kind == OP_POP_BACK) ? ring_copy[tl] : ring_copy[hd];
			if (tl == hd) begin
				// last word gone
				hd          = 0;
				tl          = 0;
				deque_empty = 1'b1;
			end else if (r.kind == OP_POP_BACK) begin
				tl = (tl == 0) ? span - 1 : tl - 1;
			end else begin
				hd = (hd + 1) % span;
			end
		end
		head_at       = IDX_W'(hd);
		tail_at       = IDX_W'(tl);
		o.is_empty    = deque_empty;
		o.front_value = deque_empty ? '0 : ring_copy[head_at];
		o.back_value  = deque_empty ? '0 : ring_copy[tail_at];
		return o;
	endfunction

	// random word, now and then one of the extremes
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: begin
				return 32'h8000_0000;
			end
			1: begin
				return 32'h7FFF_FFFF;
			end
			2: begin
				return '0;
			end
			3: begin
				return '1;
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	task automatic add_cmd(logic [1:0] k, logic [WORD_W-1:0] v);
		req_t r;
		r.kind       = k;
		r.push_value = v;
		cmd_backlog.insert(cmd_backlog.size(), r);
	endtask

	// alternate push-heavy and pop-heavy runs so the deque fills and drains
	task automatic add_random_phase(int n, logic [CAP_W-1:0] c);
		int  span;
		int  seg;
		bit  filling;
		int  count;
		span    = ring_span(c);
		filling = 1'b1;
		count   = 0;
		while (count < n) begin
			seg = $urandom_range(1, 2 * span + 2);
			for (int i = 0; i < seg && count < n; i++) begin
				if (($urandom_range(0, 3) != 0) == filling)
					add_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
				else
					add_cmd($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_word());
				count++;
			end
			filling = !filling;
		end
	endtask

	// hold until every queued word is taken and every result is back
	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || rsp_due.size() != 0 || start)
			@(posedge clk);
	endtask

	// write the capacity register; the deque empties with it
	task automatic write_capacity(logic [CAP_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid   <= 1'b0;
		cap_setting = v;
		head_at     = '0;
		tail_at     = '0;
		deque_empty = 1'b1;
		cfg_writes++;
	endtask

	// command driver: offer the oldest pending word, idle in random bursts
	always @(posedge clk) begin
		bit took;
		bit drive;
		took  = arst_n && start && !busy;
		drive = 1'b0;
		if (took) begin
			rsp_due.insert(rsp_due.size(), deque_step(req));
			cmd_backlog.delete(0);
			items_sent++;
		end
		if (!arst_n) begin
			drive = 1'b0;
		end else if (start && !took) begin
			drive = 1'b1;
		end else if (gap_left != 0) begin
			gap_left--;
		end else if (cmd_backlog.size() != 0) begin
			if (gaps_on && $urandom_range(0, 9) == 0)
				gap_left = $urandom_range(1, 8) - 1;
			else
				drive = 1'b1;
		end
		start <= drive;
		if (drive)
			req <= cmd_backlog[0];
	end

	// result monitor: compare each strobed word with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (rsp_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("[%0t] result with nothing expected: %p", $realtime, result);
			end else begin
				want = rsp_due[0];
				rsp_due.delete(0);
				results_seen++;
				if (result.status !== want.status ||
						result.popped_value !== want.popped_value ||
						result.is_empty !== want.is_empty ||
						result.front_value !== want.front_value ||
						result.back_value !== want.back_value) begin
					faults++;
					if (faults <= 10) begin
						$display("[%0t] result %0d mismatch", $realtime, results_seen);
						$display("  expected status %0d popped %h empty %b front %h back %h",
							want.status, want.popped_value, want.is_empty,
							want.front_value, want.back_value);
						$display("  actual   status %0d popped %h empty %b front %h back %h",
							result.status, result.popped_value, result.is_empty,
							result.front_value, result.back_value);
					end
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset capacity: refused pops, both wraps, last-word pops
		add_cmd(OP_POP_BACK,   32'h1234_5678);
		add_cmd(OP_POP_FRONT,  32'h0);
		add_cmd(OP_PUSH_BACK,  32'h7FFF_FFFF);
		add_cmd(OP_PUSH_FRONT, 32'h8000_0000);
		add_cmd(OP_POP_BACK,   32'h0);
		add_cmd(OP_POP_FRONT,  32'h0);
		add_cmd(OP_PUSH_FRONT, 32'h0);
		add_cmd(OP_PUSH_BACK,  32'hFFFF_FFFF);
		add_cmd(OP_PUSH_BACK,  32'h5555_5555);
		add_cmd(OP_PUSH_FRONT, 32'hAAAA_AAAA);
		add_cmd(OP_POP_FRONT,  32'h0);
		add_cmd(OP_POP_BACK,   32'h0);
		add_cmd(OP_POP_FRONT,  32'h0);
		add_cmd(OP_POP_FRONT,  32'h0);
		add_cmd(OP_POP_BACK,   32'h0);
		wait_drained();

		// two entries: fill, drop pushes at both ends, drain
		write_capacity(7'd2);
		add_cmd(OP_PUSH_BACK,  32'h0000_0001);
		add_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFE);
		add_cmd(OP_PUSH_BACK,  32'h0BAD_F00D);
		add_cmd(OP_PUSH_FRONT, 32'h7FFF_FFFF);
		add_cmd(OP_POP_FRONT,  32'h0);
		add_cmd(OP_POP_FRONT,  32'h0);
		wait_drained();

		// one entry: full after a single word
		write_capacity(7'd1);
		add_cmd(OP_PUSH_BACK,  32'h8000_0000);
		add_cmd(OP_PUSH_FRONT, 32'h0000_0042);
		add_cmd(OP_POP_BACK,   32'h0);
		add_cmd(OP_POP_FRONT,  32'h0);
		wait_drained();

		// random phases, one capacity each; the last one runs without gaps
		foreach (cap_plan[i]) begin
			if (i == 10)
				write_capacity(7'($urandom_range(0, 127)));
			else
				write_capacity(cap_plan[i]);
			gaps_on = (i != 11);
			add_random_phase(105, cap_setting);
			wait_drained();
		end

		repeat (4) @(posedge clk);
		$display("Covered %0d commands, %0d results, %0d capacity writes, %0d faults.",
			items_sent, results_seen, cfg_writes, faults);
		$display("Pushes dropped on a full deque: %0d; pops refused on an empty one: %0d.",
			full_drops, empty_refusals);
		if (faults == 0 && rsp_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("Timed out with %0d results outstanding.", rsp_due.size());
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/cdq_pkg.sv
src/cdq_ram.sv
src/circular_deque_unit.sv
tb/sv/testbench.sv
